### design/rscc_pkg.sv
// shared constants, types and crc function for the record stream crc checker
package rscc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_SEED     = 16'hFFFF;
    localparam logic [BYTE_W-1:0] LEN_AT_RESET = 8'd41;
    localparam logic [BYTE_W-1:0] LEN_MIN      = 8'd3;

    // one staged input transaction
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_stage;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### design/rscc_ifs.sv
// channel interfaces: input bytes, result items and configuration writes
interface rscc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rscc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_echo;
    logic [7:0] byte_position;
    logic       record_end;
    logic       crc_match;
    logic       failed_sticky;

    modport source (output valid, output byte_echo, output byte_position,
                    output record_end, output crc_match, output failed_sticky,
                    input ready);
    modport sink   (input valid, input byte_echo, input byte_position,
                    input record_end, input crc_match, input failed_sticky,
                    output ready);
endinterface

interface rscc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] record_length;

    modport source (output valid, output record_length, input ready);
    modport sink   (input valid, input record_length, output ready);
endinterface

### design/record_stream_crc_checker_core.sv
// path: an input transaction reaches result valid through the input register and then the result register
// throughput: 1 byte per cycle when the result side takes it; crc-16 update of all eight bit steps is combinational
// back-pressure on the result side stalls only when both registers hold data
// reset: synchronous active low; crc 0xFFFF, position 0, failure flag 0, record length 41
// configuration writes are taken every cycle and apply to the following bytes
module record_stream_crc_checker_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rscc_in_if.sink           i_in,
    rscc_cfg_if.sink          i_cfg,
    rscc_out_if.source        o_out
);
    import rscc_pkg::*;

    t_stage stage;
    logic   advance;

    assign i_cfg.ready = 1'b1;

    // input register
    rscc_input_stage u_input (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_data    (i_in.data_byte),
        .o_ready   (i_in.ready),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // crc check and result register
    rscc_check_stage u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stage         (stage),
        .o_advance       (advance),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_len       (i_cfg.record_length),
        .i_out_ready     (o_out.ready),
        .o_valid         (o_out.valid),
        .o_byte_echo     (o_out.byte_echo),
        .o_byte_position (o_out.byte_position),
        .o_record_end    (o_out.record_end),
        .o_crc_match     (o_out.crc_match),
        .o_failed_sticky (o_out.failed_sticky)
    );

endmodule

### design/rscc_input_stage.sv
// input register stage: captures one byte transaction per cycle while empty or while its byte moves on
module rscc_input_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data,
    output logic                 o_ready,
    input  logic                 i_advance,
    output rscc_pkg::t_stage     o_stage
);
    import rscc_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    // stage can take a new byte when empty or when its byte moves on
    assign o_ready = !r_valid || i_advance;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_stage = '{valid: r_valid, data: r_data};

endmodule

### design/rscc_check_stage.sv
// record state, crc update and result register
module rscc_check_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rscc_pkg::t_stage     i_stage,
    output logic                 o_advance,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_len,
    input  logic                 i_out_ready,
    output logic                 o_valid,
    output logic [7:0]           o_byte_echo,
    output logic [7:0]           o_byte_position,
    output logic                 o_record_end,
    output logic                 o_crc_match,
    output logic                 o_failed_sticky
);
    import rscc_pkg::*;

    logic [BYTE_W-1:0] r_len;
    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_pos;
    logic [BYTE_W-1:0] r_held_low;
    logic              r_fail;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_echo;
    logic [BYTE_W-1:0] r_out_pos;
    logic              r_out_end;
    logic              r_out_match;
    logic              r_out_fail;

    logic [BYTE_W-1:0] eff_len;
    logic [BYTE_W-1:0] last_pos;
    logic              is_end;
    logic              is_crc_low;
    logic              crc_ok;
    logic              fire;
    logic [CRC_W-1:0]  n_crc;
    logic [BYTE_W-1:0] n_pos;
    logic [BYTE_W-1:0] n_held_low;
    logic              n_fail;
    logic              n_match;

    // result register frees up when empty or taken
    assign o_advance = !r_out_valid || i_out_ready;
    assign fire      = i_stage.valid && o_advance;

    // record position decode
    assign eff_len    = (r_len < LEN_MIN) ? LEN_MIN : r_len;
    assign last_pos   = eff_len - 8'd1;
    assign is_end     = (r_pos >= last_pos);
    assign is_crc_low = (r_pos == last_pos - 8'd1);
    assign crc_ok     = ({i_stage.data, r_held_low} == r_crc);

    // next record state
    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos + 8'd1;
        n_held_low = r_held_low;
        n_fail     = r_fail;
        n_match    = 1'b0;
        if (is_end) begin
            n_match = crc_ok;
            n_fail  = r_fail || !crc_ok;
            n_crc   = CRC_SEED;
            n_pos   = '0;
        end else if (is_crc_low) begin
            n_held_low = i_stage.data;
        end else begin
            n_crc = crc16_byte(r_crc, i_stage.data);
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_AT_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_len;
        end
    end

    // record state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_SEED;
            r_pos      <= '0;
            r_held_low <= '0;
            r_fail     <= 1'b0;
        end else if (fire) begin
            r_crc      <= n_crc;
            r_pos      <= n_pos;
            r_held_low <= n_held_low;
            r_fail     <= n_fail;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_stage.valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_echo      <= i_stage.data;
            r_out_pos   <= r_pos;
            r_out_end   <= is_end;
            r_out_match <= n_match;
            r_out_fail  <= n_fail;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_echo     = r_echo;
    assign o_byte_position = r_out_pos;
    assign o_record_end    = r_out_end;
    assign o_crc_match     = r_out_match;
    assign o_failed_sticky = r_out_fail;

`ifndef SYNTH
    // sticky failure never clears outside reset
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_fail) |-> r_fail)
        else $error("failure flag cleared");

    // a match is only reported on a closing byte
    a_match_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_match) |-> r_out_end)
        else $error("crc match outside record end");

    // a record closes no earlier than its third byte
    a_end_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_out_pos >= 8'd2))
        else $error("record closed too early");

    // a failed record raises the reported sticky flag
    a_fail_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end && !r_out_match) |-> r_out_fail)
        else $error("failed record not flagged");

    // position counter wraps at the closing byte
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_end) |=> (r_pos == '0))
        else $error("position not cleared after record end");
`endif

endmodule

### verif/tb.sv
// testbench for the record stream crc checker: record traffic, crc prediction and result checks
`timescale 1ns / 1ps

module tb;

    localparam logic [15:0] CRC_SEED_V  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_V  = 16'hA001;
    localparam logic [7:0]  LEN_RESET_V = 8'd41;
    localparam logic [7:0]  LEN_FLOOR_V = 8'd3;
    localparam int          FILL_RANDOM = -1;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
    typedef enum {REC_GOOD, REC_BAD_CRC, REC_NOISE} record_kind_e;

    typedef struct packed {
        logic [7:0] echo;
        logic [7:0] position;
        logic       rec_end;
        logic       crc_ok;
        logic       failed;
    } result_t;

    // crc checker prediction plus the queue of results still owed by the block
    class crc_record_scoreboard;
        logic [7:0]  rec_len;
        logic [15:0] crc;
        logic [7:0]  pos;
        logic [7:0]  crc_low;
        logic        failed;
        result_t     pending_results[$];
        int          errors;
        int          checked;
        int          records_closed;
        int          records_bad;

        function new();
            rec_len = LEN_RESET_V;
            crc     = CRC_SEED_V;
            pos     = 8'd0;
            crc_low = 8'd0;
            failed  = 1'b0;
        endfunction

        // reflected crc-16, one bit per step, lsb first
        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY_V : 16'h0000);
            return r;
        endfunction

        function logic [7:0] last_pos();
            return (rec_len < LEN_FLOOR_V ? LEN_FLOOR_V : rec_len) - 8'd1;
        endfunction

        // advance the record state by one byte and return its result
        function result_t predict_byte(logic [7:0] b);
            result_t     r;
            logic [7:0]  last;
            logic [15:0] rx;
            last       = last_pos();
            r.echo     = b;
            r.position = pos;
            r.rec_end  = 1'b0;
            r.crc_ok   = 1'b0;
            if (pos >= last) begin
                rx        = {b, crc_low};
                r.rec_end = 1'b1;
                r.crc_ok  = (rx == crc);
                records_closed++;
                if (!r.crc_ok) begin
                    failed = 1'b1;
                    records_bad++;
                end
                crc = CRC_SEED_V;
                pos = 8'd0;
            end else begin
                if (pos == last - 8'd1) begin
                    crc_low = b;
                end else begin
                    crc = crc_update(crc, b);
                end
                pos = pos + 8'd1;
            end
            r.failed = failed;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            pending_results.push_back(predict_byte(b));
        endfunction

        function void report(string field, int unsigned exp_v, int unsigned act_v);
            errors++;
            $display("%0t ns %s: expected %0h, actual %0h", $time, field, exp_v, act_v);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns unexpected result: echo %0h position %0d", $time,
                         got.echo, got.position);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.echo !== want.echo) report("byte_echo", want.echo, got.echo);
            if (got.position !== want.position)
                report("byte_position", want.position, got.position);
            if (got.rec_end !== want.rec_end) report("record_end", want.rec_end, got.rec_end);
            if (got.crc_ok !== want.crc_ok) report("crc_match", want.crc_ok, got.crc_ok);
            if (got.failed !== want.failed)
                report("failed_sticky", want.failed, got.failed);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rscc_in_if  in_ch ();
    rscc_cfg_if cfg_ch ();
    rscc_out_if out_ch ();

    record_stream_crc_checker_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // sb checks results, planner only tracks record position while building stimulus
    crc_record_scoreboard sb      = new();
    crc_record_scoreboard planner = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("record_stream_crc_checker_core: mismatch");
        $finish;
    end

    // result side ready, with random stalls and an occasional long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_mon
        result_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.echo     = out_ch.byte_echo;
            got.position = out_ch.byte_position;
            got.rec_end  = out_ch.record_end;
            got.crc_ok   = out_ch.crc_match;
            got.failed   = out_ch.failed_sticky;
            sb.check_result(got);
        end
    end

    task automatic set_idle(idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;  recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 85; recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct = 0;  recv_stall_pct = 85;
            end
            default: begin
                send_idle_pct = 34; recv_stall_pct = 34;
            end
        endcase
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_length(logic [7:0] len);
        @(negedge i_clk);
        cfg_ch.valid         = 1'b1;
        cfg_ch.record_length = len;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.rec_len      = len;
        planner.rec_len = len;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_byte(logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    task automatic send_stream(ref logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // append one record; a partial record left from before is closed with random bytes first
    function automatic void build_record(ref logic [7:0] q[$], input record_kind_e kind,
                                         input int fill);
        logic [7:0]  b;
        logic [15:0] c;
        int          n;
        int          start;
        int          flip;
        while (planner.pos != 8'd0) begin
            b = 8'($urandom);
            q.push_back(b);
            void'(planner.predict_byte(b));
        end
        n     = int'(planner.last_pos()) + 1;
        start = q.size();
        if (kind == REC_NOISE) begin
            repeat (n) q.push_back(8'($urandom));
        end else begin
            c = CRC_SEED_V;
            repeat (n - 2) begin
                b = (fill < 0) ? 8'($urandom) : 8'(fill);
                c = crc_record_scoreboard::crc_update(c, b);
                q.push_back(b);
            end
            q.push_back(c[7:0]);
            q.push_back(c[15:8]);
            if (kind == REC_BAD_CRC) begin
                flip    = $urandom_range(q.size() - 1, start);
                q[flip] = q[flip] ^ (8'd1 << $urandom_range(7));
            end
        end
        for (int k = start; k < q.size(); k++) void'(planner.predict_byte(q[k]));
    endfunction

    task automatic run_phase(int len, idle_mode_e mode, int budget, int hold);
        logic [7:0]   q[$];
        int           pick;
        record_kind_e kind;
        wait_drained();
        write_length(len[7:0]);
        set_idle(mode);
        hold_left = hold;
        while (q.size() < budget) begin
            pick = $urandom_range(99);
            kind = (pick < 70) ? REC_GOOD : (pick < 85) ? REC_BAD_CRC : REC_NOISE;
            build_record(q, kind, FILL_RANDOM);
        end
        send_stream(q);
    endtask

    initial begin
        logic [7:0] q[$];
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = 8'h00;
        cfg_ch.valid         = 1'b0;
        cfg_ch.record_length = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: partial record at the reset length, then shrink mid-record
        set_idle(IDLE_NONE);
        repeat (6) q.push_back(8'($urandom));
        foreach (q[i]) void'(planner.predict_byte(q[i]));
        send_stream(q);
        wait_drained();
        write_length(8'd3);
        q.delete();
        // first byte closes the record with a never-written crc low byte
        q.push_back(8'h5A);
        void'(planner.predict_byte(8'h5A));
        build_record(q, REC_GOOD, 8'h00);
        build_record(q, REC_GOOD, 8'hFF);
        build_record(q, REC_BAD_CRC, FILL_RANDOM);
        // checking resumes after the failure
        build_record(q, REC_GOOD, FILL_RANDOM);
        send_stream(q);

        // zero length behaves as three
        wait_drained();
        write_length(8'd0);
        q.delete();
        build_record(q, REC_GOOD, 8'h00);
        send_stream(q);

        // grow the length in the middle of a record
        wait_drained();
        write_length(8'd8);
        q.delete();
        repeat (4) q.push_back(8'($urandom));
        foreach (q[i]) void'(planner.predict_byte(q[i]));
        send_stream(q);
        wait_drained();
        write_length(8'd12);

        // random record traffic over a range of lengths and idling
        run_phase(41, IDLE_NONE, 100, 0);
        run_phase(3, IDLE_SEND, 60, 0);
        run_phase(255, IDLE_RECV, 200, 0);
        run_phase(1, IDLE_BOTH, 45, 0);
        run_phase(17, IDLE_NONE, 120, 300);
        run_phase($urandom_range(40, 4), IDLE_RECV, 90, 0);
        run_phase(2, IDLE_SEND, 45, 0);
        run_phase($urandom_range(64, 3), IDLE_BOTH, 150, 0);
        run_phase(41, IDLE_NONE, 60, 0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("checked %0d bytes, %0d records closed, %0d of them with a bad crc",
                 sb.checked, sb.records_closed, sb.records_bad);
        $display("lengths 0 to 255, mid-record length changes, stalls and a long hold-off");
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("record_stream_crc_checker_core: match");
        end else begin
            $display("record_stream_crc_checker_core: mismatch");
        end
        $finish;
    end

endmodule
